// ===== rtl/tbpr_pkg.sv =====
// Shared types and constants for the tile background pixel renderer.
// No dependencies; every other file but tbpr_ram imports this package.
package tbpr_pkg;

   // Video RAM geometry: two byte banks (even and odd byte offsets)
   localparam int unsigned VRAM_BYTES    = 8192;
   localparam int unsigned VRAM_OFS_W    = 13;
   localparam int unsigned BANK_DEPTH    = VRAM_BYTES / 2;
   localparam int unsigned BANK_IDX_W    = VRAM_OFS_W - 1;

   // Item codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_DISPLAY_CONTROL = 3'd0;
   localparam logic [2:0] CSR_SCROLL_X        = 3'd1;
   localparam logic [2:0] CSR_SCROLL_Y        = 3'd2;
   localparam logic [2:0] CSR_WINDOW_X        = 3'd3;
   localparam logic [2:0] CSR_WINDOW_Y        = 3'd4;
   localparam logic [2:0] CSR_BG_PALETTE      = 3'd5;

   // display_control bit positions
   localparam int unsigned DC_BG_ON       = 0;
   localparam int unsigned DC_BG_MAP      = 3;
   localparam int unsigned DC_DATA_UNSIGN = 4;
   localparam int unsigned DC_WIN_ON      = 5;
   localparam int unsigned DC_WIN_MAP     = 6;
   localparam int unsigned DC_DISPLAY_ON  = 7;

   // Offsets from the base of video RAM (0x8000)
   localparam logic [12:0] MAP_LOW_OFS     = 13'h1800;  // 0x9800
   localparam logic [12:0] MAP_HIGH_OFS    = 13'h1c00;  // 0x9c00
   localparam logic [12:0] DATA_SIGNED_OFS = 13'h0800;  // 0x8800
   localparam logic [7:0]  TILE_SIGN_FLIP  = 8'h80;
   localparam logic [7:0]  WINDOW_X_BIAS   = 8'd7;
   localparam logic [1:0]  SHADE_MASK      = 2'h3;

   typedef struct packed {
      logic [7:0] display_control;
      logic [7:0] scroll_x;
      logic [7:0] scroll_y;
      logic [7:0] window_x;
      logic [7:0] window_y;
      logic [7:0] bg_palette;
   } cfg_type;

   // Stage after the map read was issued
   typedef struct packed {
      logic [7:0] out_x;
      logic [7:0] out_line;
      logic       on;
      logic       map_bank;
      logic [2:0] fine_x;
      logic [2:0] fine_y;
   } map_stage_type;

   // Stage after the tile row read was issued
   typedef struct packed {
      logic [7:0] out_x;
      logic [7:0] out_line;
      logic       on;
      logic [2:0] fine_x;
   } tile_stage_type;

endpackage

// ===== rtl/tbpr_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies. A read at the written address returns the old contents.
module tbpr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic                     rd_en_b,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/tbpr_map_stage.sv =====
// Coordinate transform and tile map address for an incoming render beat.
// Depends on tbpr_pkg; holds the first pipeline stage.
module tbpr_map_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  tbpr_pkg::cfg_type             cfg,
   input  logic                          advance,
   input  logic                          load_render,
   input  logic [7:0]                    pixel_x,
   input  logic [7:0]                    line_num,
   output logic [tbpr_pkg::BANK_IDX_W-1:0] map_idx,
   output logic                          stage_valid,
   output tbpr_pkg::map_stage_type       stage
);
   import tbpr_pkg::*;

   logic          win;
   logic          map_sel;
   logic [7:0]    win_left;
   logic [7:0]    plane_x;
   logic [7:0]    plane_y;
   logic [12:0]   map_ofs;
   logic          valid_ff;
   logic          valid_in;
   map_stage_type stage_ff;
   map_stage_type stage_in;

   // Background or window plane coordinates
   always_comb begin
      win      = cfg.display_control[DC_WIN_ON] && (line_num >= cfg.window_y);
      map_sel  = win ? cfg.display_control[DC_WIN_MAP] : cfg.display_control[DC_BG_MAP];
      win_left = cfg.window_x - WINDOW_X_BIAS;
      if (win) begin
         plane_x = pixel_x - win_left;
         plane_y = line_num - cfg.window_y;
      end else begin
         plane_x = pixel_x + cfg.scroll_x;
         plane_y = line_num + cfg.scroll_y;
      end
      // 32x32 map entry: row y/8, column x/8
      map_ofs = (map_sel ? MAP_HIGH_OFS : MAP_LOW_OFS)
                | {3'b000, plane_y[7:3], plane_x[7:3]};
      map_idx = map_ofs[12:1];
   end

   always_comb begin
      stage_in.out_x    = pixel_x;
      stage_in.out_line = line_num;
      stage_in.on       = cfg.display_control[DC_DISPLAY_ON] && cfg.display_control[DC_BG_ON];
      stage_in.map_bank = map_ofs[0];
      stage_in.fine_x   = plane_x[2:0];
      stage_in.fine_y   = plane_y[2:0];
      valid_in          = advance ? load_render : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

// ===== rtl/tbpr_tile_stage.sv =====
// Tile number to tile data row address, second pipeline stage.
// Depends on tbpr_pkg; consumes the map byte read by the first stage.
module tbpr_tile_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  tbpr_pkg::cfg_type               cfg,
   input  logic                            advance,
   input  logic                            prev_valid,
   input  tbpr_pkg::map_stage_type         prev,
   input  logic [7:0]                      map_even,
   input  logic [7:0]                      map_odd,
   output logic [tbpr_pkg::BANK_IDX_W-1:0] row_idx,
   output logic                            stage_valid,
   output tbpr_pkg::tile_stage_type        stage
);
   import tbpr_pkg::*;

   logic           [7:0]  tile_idx;
   logic           [12:0] tile_ofs;
   logic                  valid_ff;
   logic                  valid_in;
   tile_stage_type        stage_ff;
   tile_stage_type        stage_in;

   // Unsigned data from 0x8000, signed data centered on 0x9000
   always_comb begin
      tile_idx = prev.map_bank ? map_odd : map_even;
      if (cfg.display_control[DC_DATA_UNSIGN]) begin
         tile_ofs = {1'b0, tile_idx, 4'h0};
      end else begin
         tile_ofs = DATA_SIGNED_OFS + {1'b0, tile_idx ^ TILE_SIGN_FLIP, 4'h0};
      end
      // Row pair: even byte in one bank, odd byte in the other
      row_idx = {tile_ofs[12:4], prev.fine_y};
   end

   always_comb begin
      stage_in.out_x    = prev.out_x;
      stage_in.out_line = prev.out_line;
      stage_in.on       = prev.on;
      stage_in.fine_x   = prev.fine_x;
      valid_in          = advance ? prev_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

// ===== rtl/tbpr_pixel_stage.sv =====
// Colour id, palette lookup and the result output register.
// Depends on tbpr_pkg; consumes the tile row bytes read by the second stage.
module tbpr_pixel_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  tbpr_pkg::cfg_type        cfg,
   input  logic                     advance,
   input  logic                     prev_valid,
   input  tbpr_pkg::tile_stage_type prev,
   input  logic [7:0]               row_lo,
   input  logic [7:0]               row_hi,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_x,
   output logic [7:0]               rsp_out_line,
   output logic [1:0]               rsp_shade,
   output logic                     rsp_drawn
);
   import tbpr_pkg::*;

   logic [2:0] bit_sel;
   logic [1:0] pal_sel;
   logic [1:0] shade_in;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] out_x_ff;
   logic [7:0] out_line_ff;
   logic [1:0] shade_ff;
   logic       drawn_ff;

   // Column c uses bit 7-c; the first byte carries weight two
   always_comb begin
      bit_sel  = ~prev.fine_x;
      pal_sel  = {row_lo[bit_sel], row_hi[bit_sel]};
      case (pal_sel)
         2'd0:    shade_in = cfg.bg_palette[1:0] & SHADE_MASK;
         2'd1:    shade_in = cfg.bg_palette[3:2] & SHADE_MASK;
         2'd2:    shade_in = cfg.bg_palette[5:4] & SHADE_MASK;
         default: shade_in = cfg.bg_palette[7:6] & SHADE_MASK;
      endcase
      if (!prev.on) begin
         shade_in = 2'd0;
      end
      valid_in = advance ? prev_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff    <= prev.out_x;
         out_line_ff <= prev.out_line;
         shade_ff    <= shade_in;
         drawn_ff    <= prev.on;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_x    = out_x_ff;
   assign rsp_out_line = out_line_ff;
   assign rsp_shade    = shade_ff;
   assign rsp_drawn    = drawn_ff;

endmodule

// ===== rtl/tile_background_pixel_renderer_unit.sv =====
// Top level of the tile background pixel renderer: registers, video RAM banks
// and the three-stage pixel pipeline. Depends on tbpr_pkg and all tbpr_ modules.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall opcode, vram_offset, vram_byte, pixel_x, line_num
//   rsp      out  rsp_valid/rsp_stall out_x, out_line, shade, drawn
//   csr      in   csr_write_enable    csr_index, csr_write_data
//
// One beat per cycle enters while req_stall is low; a render result passes the map,
// tile and pixel stage registers on its way out. The rate is set by the read port
// count of the two video RAM banks (map read on port a, tile row pair on port b);
// video RAM writes give no beat. Each stage holds only while the stage after it is
// full and held, so a waiting result still lets new beats in until all stages are full.
// Reset clears the configuration registers and stage valid bits; video RAM content is not cleared.
module tile_background_pixel_renderer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [12:0] req_vram_offset,
   input  logic [7:0]  req_vram_byte,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_line_num,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_x,
   output logic [7:0]  rsp_out_line,
   output logic [1:0]  rsp_shade,
   output logic        rsp_drawn,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_write_data
);
   import tbpr_pkg::*;

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic                    adv_map;
   logic                    adv_tile;
   logic                    adv_out;
   logic                    req_accept;
   logic                    vram_wr;
   logic [BANK_IDX_W-1:0]   map_idx;
   logic [BANK_IDX_W-1:0]   row_idx;
   logic                    map_valid;
   map_stage_type           map_stage;
   logic                    tile_valid;
   tile_stage_type          tile_stage;
   logic [7:0]              map_even;
   logic [7:0]              map_odd;
   logic [7:0]              row_lo;
   logic [7:0]              row_hi;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DISPLAY_CONTROL: cfg_in.display_control = csr_write_data;
            CSR_SCROLL_X:        cfg_in.scroll_x        = csr_write_data;
            CSR_SCROLL_Y:        cfg_in.scroll_y        = csr_write_data;
            CSR_WINDOW_X:        cfg_in.window_x        = csr_write_data;
            CSR_WINDOW_Y:        cfg_in.window_y        = csr_write_data;
            CSR_BG_PALETTE:      cfg_in.bg_palette      = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage advance: a stage moves when the one after it is empty or moving
   assign adv_out    = !rsp_valid || !rsp_stall;
   assign adv_tile   = !tile_valid || adv_out;
   assign adv_map    = !map_valid || adv_tile;
   assign req_stall  = !adv_map;
   assign req_accept = req_valid && adv_map;
   assign vram_wr    = req_accept && (req_opcode == OP_WRITE);

   // Video RAM split into even and odd byte banks
   tbpr_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
   ) u_bank_even (
      .clock     (clock),
      .wr_en     (vram_wr && !req_vram_offset[0]),
      .wr_addr   (req_vram_offset[12:1]),
      .wr_data   (req_vram_byte),
      .rd_en_a   (adv_map),
      .rd_addr_a (map_idx),
      .rd_data_a (map_even),
      .rd_en_b   (adv_tile),
      .rd_addr_b (row_idx),
      .rd_data_b (row_lo)
   );

   tbpr_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
   ) u_bank_odd (
      .clock     (clock),
      .wr_en     (vram_wr && req_vram_offset[0]),
      .wr_addr   (req_vram_offset[12:1]),
      .wr_data   (req_vram_byte),
      .rd_en_a   (adv_map),
      .rd_addr_a (map_idx),
      .rd_data_a (map_odd),
      .rd_en_b   (adv_tile),
      .rd_addr_b (row_idx),
      .rd_data_b (row_hi)
   );

   // Pipeline
   tbpr_map_stage u_map_stage (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .advance     (adv_map),
      .load_render (req_valid && (req_opcode == OP_RENDER)),
      .pixel_x     (req_pixel_x),
      .line_num    (req_line_num),
      .map_idx     (map_idx),
      .stage_valid (map_valid),
      .stage       (map_stage)
   );

   tbpr_tile_stage u_tile_stage (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .advance     (adv_tile),
      .prev_valid  (map_valid),
      .prev        (map_stage),
      .map_even    (map_even),
      .map_odd     (map_odd),
      .row_idx     (row_idx),
      .stage_valid (tile_valid),
      .stage       (tile_stage)
   );

   tbpr_pixel_stage u_pixel_stage (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .advance      (adv_out),
      .prev_valid   (tile_valid),
      .prev         (tile_stage),
      .row_lo       (row_lo),
      .row_hi       (row_hi),
      .rsp_valid    (rsp_valid),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_line (rsp_out_line),
      .rsp_shade    (rsp_shade),
      .rsp_drawn    (rsp_drawn)
   );

   // Pipeline full and output held: input must stall
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && tile_valid && map_valid) |-> req_stall)
      else $error("input taken while every stage is full and held");

   // A write beat, or an idle cycle that advances the first stage, leaves it empty
   a_write_no_stage: assert property (@(posedge clock) disable iff (reset)
      (adv_map && !(req_valid && (req_opcode == OP_RENDER))) |=> !map_valid)
      else $error("first stage filled without a render beat");

   // A held tile stage keeps its beat
   a_tile_hold: assert property (@(posedge clock) disable iff (reset)
      (tile_valid && !adv_tile) |=> (tile_valid && $stable(tile_stage)))
      else $error("tile stage lost its beat while held");

   // Disabled background or display always gives shade zero
   a_off_shade: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_drawn) |-> (rsp_shade == 2'd0))
      else $error("undrawn pixel with nonzero shade");

endmodule
